// File: rtl/core/cpbr_pkg.sv
// ----------------------------------------------------------------------------
// Closest points between rays: shared definitions
// Widths, register map and helper functions used by the core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpbr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int NIN       = 12;
	localparam int NOUT      = 8;
	localparam int THR_W     = 31;

	localparam int DEN_W     = 128;
	localparam int EC_W      = 97;
	localparam int DET_W     = 132;
	localparam int NW        = 168;
	localparam int ND        = 8;
	localparam int QB        = 34;
	localparam int PT_W      = QB + 3;

	localparam int DIV0      = 12;
	localparam int NST       = DIV0 + QB;

	localparam int PADDR_W   = 3;
	localparam logic REG_PARALLEL_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [5:0][DW-1:0] org;
		logic [DEN_W-1:0]   den;
		logic               par;
		logic [ND-1:0]      neg;
		logic [ND-1:0]      ovf;
	} side_t;

	function automatic logic [DW-1:0] sat32(input logic signed [PT_W-1:0] v);
		logic [DW-1:0] r;
		if (v > $signed({{(PT_W-DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
			r = {1'b0, {(DW-1){1'b1}}};
		end else if (v < $signed({{(PT_W-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/closest_points_between_rays_core.sv
// ----------------------------------------------------------------------------
// Closest points between two 3D lines
// Exact fixed-point cross product, determinants and rounded pipelined divides.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the s_ channel carries two lines (origin and direction each,
// signed fixed point). Each beat on the m_ channel carries the two closest
// points and both line parameters; m_tuser is high when the lines are not
// parallel, otherwise all data bits are zero.
// The parallel threshold register is to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
// One beat is accepted per cycle while the receiver does not stall; the pipeline
// has 46 register stages, 34 of which form the restoring divider array, one
// quotient bit per stage.
// Reset clears all valid bits and sets the threshold to one LSB.
// When the receiver stalls, stages fill up one by one and bubbles collapse;
// s_tready falls only once every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_points_between_rays_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// a_origin_x/y/z, a_dir_x/y/z, b_origin_x/y/z, b_dir_x/y/z
	input  wire logic [cpbr_pkg::NIN*cpbr_pkg::DW-1:0] s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// a_point_x/y/z, b_point_x/y/z, a_param, b_param
	output logic [cpbr_pkg::NOUT*cpbr_pkg::DW-1:0]     m_tdata,
	// found
	output logic                                       m_tuser,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [cpbr_pkg::PADDR_W-1:0]          paddr,
	input  wire logic [31:0]                           pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready
);

	import cpbr_pkg::*;

	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

	logic [NST+1:1] en;
	logic [NST:1]   vld_q;
	logic [THR_W-1:0] thr_q;
	logic [DEN_W-1:0] lim;

	logic [5:0][DW-1:0] org_s1, org_s2, org_s3, org_s4, org_s5, org_s6, org_s7, org_s8;
	logic [5:0][DW-1:0] org_s9, org_s10;
	logic [2:0][DW-1:0] ad_s1, ad_s2, ad_s3, ad_s4, ad_s5, ad_s6, ad_s7;
	logic [2:0][DW-1:0] bd_s1, bd_s2, bd_s3, bd_s4, bd_s5, bd_s6, bd_s7;
	logic [2:0][DW:0]   d_s2, d_s3, d_s4, d_s5;
	logic [2:0][63:0]   cp_s2, cn_s2, c_s3;
	logic [2:0][63:0]   sqhh_s4, sqll_s4;
	logic [2:0][64:0]   sqhl_s4;
	logic [1:0][2:0][63:0] pjh_s4, pkh_s4;
	logic [1:0][2:0][64:0] pjl_s4, pkl_s4;
	logic [DEN_W-1:0]   den_s5, den_s6, den_s7, den_s8, den_s9, den_s10;
	logic [1:0][2:0][EC_W-1:0] ec_s5;
	logic               par_s6, par_s7, par_s8, par_s9, par_s10;
	logic [1:0][2:0][2:0][65:0] dp_s6;
	logic [1:0][DET_W-1:0] det_s7, det_s8;
	logic [5:0][4:0][64:0] np_s8;
	logic [ND-1:0][NW-1:0] num_s9, mag_s10;
	logic [ND-1:0]      neg_s10;

	side_t                 dv_side_s [QB+1];
	logic [ND-1:0][NW-1:0] dv_rem_s  [QB+1];
	logic [ND-1:0][QB-1:0] dv_quo_s  [QB+1];

	logic               found_s46;
	logic [NOUT-1:0][DW-1:0] res_s46;

	logic [129:0]       den_nx;
	logic [1:0][2:0][EC_W-1:0] ec_nx;
	logic [1:0][DET_W-1:0] det_nx;
	logic [1:0][4:0][32:0] limb;
	logic [ND-1:0][NW-1:0] num_nx;
	logic [NOUT-1:0][DW-1:0] res_nx;

	// Handshake and configuration.

	always_comb begin
		en[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NST];
	assign m_tuser  = found_s46;
	assign m_tdata  = res_s46;
	assign pready   = 1'b1;
	assign prdata   = (paddr[PADDR_W-1] == REG_PARALLEL_THRESHOLD) ? {1'b0, thr_q} : '0;
	assign lim      = DEN_W'(thr_q) << (3 * FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= THR_W'(1);
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (psel && penable && pwrite && pready &&
			    paddr[PADDR_W-1] == REG_PARALLEL_THRESHOLD) begin
				thr_q <= pwdata[THR_W-1:0];
			end
		end
	end

	// Stages 1 to 4: input, cross product, partial products.

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				org_s1[i]   <= s_tdata[DW*i +: DW];
				ad_s1[i]    <= s_tdata[DW*(3+i) +: DW];
				org_s1[3+i] <= s_tdata[DW*(6+i) +: DW];
				bd_s1[i]    <= s_tdata[DW*(9+i) +: DW];
			end
		end
		if (en[2]) begin
			org_s2 <= org_s1;
			ad_s2  <= ad_s1;
			bd_s2  <= bd_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i]  <= (DW+1)'($signed(org_s1[3+i])) - (DW+1)'($signed(org_s1[i]));
				cp_s2[i] <= 64'($signed(ad_s1[NXT1[i]]) * $signed(bd_s1[NXT2[i]]));
				cn_s2[i] <= 64'($signed(ad_s1[NXT2[i]]) * $signed(bd_s1[NXT1[i]]));
			end
		end
		if (en[3]) begin
			org_s3 <= org_s2;
			ad_s3  <= ad_s2;
			bd_s3  <= bd_s2;
			d_s3   <= d_s2;
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= cp_s2[i] - cn_s2[i];
			end
		end
		if (en[4]) begin
			org_s4 <= org_s3;
			ad_s4  <= ad_s3;
			bd_s4  <= bd_s3;
			d_s4   <= d_s3;
			for (int i = 0; i < 3; i++) begin
				sqhh_s4[i] <= 64'($signed(c_s3[i][63:32]) * $signed(c_s3[i][63:32]));
				sqhl_s4[i] <= 65'($signed(c_s3[i][63:32]) * $signed({1'b0, c_s3[i][31:0]}));
				sqll_s4[i] <= 64'(c_s3[i][31:0] * c_s3[i][31:0]);
				for (int e = 0; e < 2; e++) begin
					pjh_s4[e][i] <= 64'($signed(e == 0 ? bd_s3[NXT1[i]] : ad_s3[NXT1[i]]) *
					                    $signed(c_s3[NXT2[i]][63:32]));
					pjl_s4[e][i] <= 65'($signed(e == 0 ? bd_s3[NXT1[i]] : ad_s3[NXT1[i]]) *
					                    $signed({1'b0, c_s3[NXT2[i]][31:0]}));
					pkh_s4[e][i] <= 64'($signed(e == 0 ? bd_s3[NXT2[i]] : ad_s3[NXT2[i]]) *
					                    $signed(c_s3[NXT1[i]][63:32]));
					pkl_s4[e][i] <= 65'($signed(e == 0 ? bd_s3[NXT2[i]] : ad_s3[NXT2[i]]) *
					                    $signed({1'b0, c_s3[NXT1[i]][31:0]}));
				end
			end
		end
	end

	// Stages 5 to 7: squared length, inner cross products, determinants.

	always_comb begin
		den_nx = '0;
		for (int i = 0; i < 3; i++) begin
			den_nx = den_nx + (130'($signed(sqhh_s4[i])) << 64) +
			         (130'($signed(sqhl_s4[i])) << 33) + 130'(sqll_s4[i]);
			for (int e = 0; e < 2; e++) begin
				ec_nx[e][i] = (EC_W'($signed(pjh_s4[e][i])) << 32) + EC_W'($signed(pjl_s4[e][i]))
				            - (EC_W'($signed(pkh_s4[e][i])) << 32) - EC_W'($signed(pkl_s4[e][i]));
			end
		end
	end

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			det_nx[e] = '0;
			for (int i = 0; i < 3; i++) begin
				det_nx[e] = det_nx[e] + DET_W'($signed(dp_s6[e][i][0])) +
				            (DET_W'($signed(dp_s6[e][i][1])) << 32) +
				            (DET_W'($signed(dp_s6[e][i][2])) << 64);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			org_s5 <= org_s4;
			ad_s5  <= ad_s4;
			bd_s5  <= bd_s4;
			d_s5   <= d_s4;
			den_s5 <= den_nx[DEN_W-1:0];
			ec_s5  <= ec_nx;
		end
		if (en[6]) begin
			org_s6 <= org_s5;
			ad_s6  <= ad_s5;
			bd_s6  <= bd_s5;
			den_s6 <= den_s5;
			par_s6 <= den_s5 <= lim;
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s6[e][i][0] <= 66'($signed(d_s5[i]) * $signed({1'b0, ec_s5[e][i][31:0]}));
					dp_s6[e][i][1] <= 66'($signed(d_s5[i]) * $signed({1'b0, ec_s5[e][i][63:32]}));
					dp_s6[e][i][2] <= 66'($signed(d_s5[i]) * $signed(ec_s5[e][i][96:64]));
				end
			end
		end
		if (en[7]) begin
			org_s7 <= org_s6;
			ad_s7  <= ad_s6;
			bd_s7  <= bd_s6;
			den_s7 <= den_s6;
			par_s7 <= par_s6;
			det_s7 <= det_nx;
		end
	end

	// Stages 8 to 11: numerators, magnitudes, overflow check.

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			for (int l = 0; l < 4; l++) begin
				limb[e][l] = {1'b0, det_s7[e][32*l +: 32]};
			end
			limb[e][4] = {{29{det_s7[e][DET_W-1]}}, det_s7[e][DET_W-1:128]};
		end
	end

	always_comb begin
		for (int n = 0; n < 6; n++) begin
			num_nx[n] = '0;
			for (int l = 0; l < 5; l++) begin
				num_nx[n] = num_nx[n] + (NW'($signed(np_s8[n][l])) << (32 * l));
			end
		end
		num_nx[6] = NW'($signed(det_s8[0])) << FRAC_BITS;
		num_nx[7] = NW'($signed(det_s8[1])) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			org_s8 <= org_s7;
			den_s8 <= den_s7;
			par_s8 <= par_s7;
			det_s8 <= det_s7;
			for (int i = 0; i < 3; i++) begin
				for (int l = 0; l < 5; l++) begin
					np_s8[i][l]   <= 65'($signed(ad_s7[i]) * $signed(limb[0][l]));
					np_s8[3+i][l] <= 65'($signed(bd_s7[i]) * $signed(limb[1][l]));
				end
			end
		end
		if (en[9]) begin
			org_s9 <= org_s8;
			den_s9 <= den_s8;
			par_s9 <= par_s8;
			num_s9 <= num_nx;
		end
		if (en[10]) begin
			org_s10 <= org_s9;
			den_s10 <= den_s9;
			par_s10 <= par_s9;
			for (int n = 0; n < ND; n++) begin
				neg_s10[n] <= num_s9[n][NW-1];
				mag_s10[n] <= num_s9[n][NW-1] ? -num_s9[n] : num_s9[n];
			end
		end
		if (en[DIV0-1]) begin
			dv_side_s[0].org <= org_s10;
			dv_side_s[0].den <= den_s10;
			dv_side_s[0].par <= par_s10;
			dv_side_s[0].neg <= neg_s10;
			for (int n = 0; n < ND; n++) begin
				dv_side_s[0].ovf[n] <= mag_s10[n] >= (NW'(den_s10) << QB);
			end
			dv_rem_s[0] <= mag_s10;
			dv_quo_s[0] <= '0;
		end
	end

	// Divider array: one quotient bit per stage, most significant first.

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int SH = QB - 1 - j;
		logic [NW-1:0] dsh;

		assign dsh = NW'(dv_side_s[j].den) << SH;

		always_ff @(posedge clk) begin
			if (en[DIV0+j]) begin
				dv_side_s[j+1] <= dv_side_s[j];
				for (int n = 0; n < ND; n++) begin
					if (dv_rem_s[j][n] >= dsh) begin
						dv_rem_s[j+1][n] <= dv_rem_s[j][n] - dsh;
						dv_quo_s[j+1][n] <= dv_quo_s[j][n] | (QB'(1) << SH);
					end else begin
						dv_rem_s[j+1][n] <= dv_rem_s[j][n];
						dv_quo_s[j+1][n] <= dv_quo_s[j][n];
					end
				end
			end
		end
	end

	// Output stage: rounding, sign, origin offset and saturation.

	always_comb begin
		logic          up;
		logic [QB:0]   mg;
		logic signed [PT_W-1:0] v;
		for (int n = 0; n < ND; n++) begin
			up = {dv_rem_s[QB][n][DEN_W-1:0], 1'b0} >= {1'b0, dv_side_s[QB].den};
			mg = (QB+1)'(dv_quo_s[QB][n]) + (QB+1)'(up);
			if (dv_side_s[QB].ovf[n]) begin
				mg = (QB+1)'(1) << QB;
			end
			v = $signed(PT_W'(mg));
			if (dv_side_s[QB].neg[n]) begin
				v = -v;
			end
			if (n < 6) begin
				v = v + PT_W'($signed(dv_side_s[QB].org[n]));
			end
			res_nx[n] = sat32(v);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			found_s46 <= !dv_side_s[QB].par;
			res_s46   <= dv_side_s[QB].par ? '0 : res_nx;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cpbr_checker.sv
// ----------------------------------------------------------------------------
// Closest points between rays: port checker
// Concurrent checks on the core's stream and register ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbr_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  s_tvalid,
	input wire logic                                  s_tready,
	input wire logic [cpbr_pkg::NIN*cpbr_pkg::DW-1:0] s_tdata,
	input wire logic                                  m_tvalid,
	input wire logic                                  m_tready,
	input wire logic [cpbr_pkg::NOUT*cpbr_pkg::DW-1:0] m_tdata,
	input wire logic                                  m_tuser,
	input wire logic                                  psel,
	input wire logic                                  penable,
	input wire logic                                  pwrite,
	input wire logic [cpbr_pkg::PADDR_W-1:0]          paddr,
	input wire logic [31:0]                           pwdata,
	input wire logic [31:0]                           prdata,
	input wire logic                                  pready
);

	import cpbr_pkg::*;

	logic wr_thr;

	assign wr_thr = psel && penable && pwrite && pready &&
	                paddr[PADDR_W-1] == REG_PARALLEL_THRESHOLD;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("parallel result carries nonzero data");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without an output stall");

	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_thr |=> paddr[PADDR_W-1] != REG_PARALLEL_THRESHOLD ||
		           prdata == {1'b0, $past(pwdata[THR_W-1:0])})
		else $error("threshold readback mismatch");

endmodule

bind closest_points_between_rays_core cpbr_checker u_cpbr_checker (.*);

`default_nettype wire
